@@ src/ldrt_pkg.sv @@
package ldrt_pkg;

    localparam int ALPHABET_SIZE  = 256;
    localparam int POSITION_WIDTH = 32;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 9;
    localparam int SYM_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    localparam int LEN_CAP = 256;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

    // Byte to table symbol. The alphabet size is a power of two, so the
    // reduction keeps the low bits of the byte.
    function automatic logic [SYM_W-1:0] sym_of(input logic [CHAR_W-1:0] c);
        return SYM_W'(32'(c) % ALPHABET_SIZE);
    endfunction

endpackage

@@ src/longest_distinct_run_tracker_unit.sv @@
// Longest distinct run tracker. One byte item is taken per cycle unless the
// output stalls, and each item returns, through the stage-one and output
// registers, the length of the repeat-free window ending at that byte, the
// best such length in the current string and a sticky overflow flag of the
// position counter. The rate is set by the last-seen table: a synchronous
// memory read when the item is accepted and a write when it leaves stage
// one, with a forwarding path for back-to-back items on the same byte value.
// The table is cleared at reset through one seen bit per entry, so no
// clearing pass is needed and the block is ready right after reset.
module longest_distinct_run_tracker_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ldrt_pkg::CHAR_W-1:0] i_char_in,
    input  logic                        i_first_of_string,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ldrt_pkg::LEN_W-1:0]  o_window_length,
    output logic [ldrt_pkg::LEN_W-1:0]  o_best_length,
    output logic                        o_position_overflow
);

    localparam int PW = ldrt_pkg::POSITION_WIDTH;
    localparam int LW = ldrt_pkg::LEN_W;
    localparam int SW = ldrt_pkg::SYM_W;
    localparam int AS = ldrt_pkg::ALPHABET_SIZE;

    // Last-seen table and its seen bits.
    logic [PW-1:0] r_mem [AS];
    logic [AS-1:0] r_seen;

    // Front state.
    logic [PW-1:0] r_pos;
    logic          r_ovf;

    // Stage one item.
    logic          r_s1_valid;
    logic [SW-1:0] r_s1_sym;
    logic [PW-1:0] r_s1_pos;
    logic          r_s1_ovf;
    logic          r_s1_first;
    logic [PW-1:0] r_rd;
    logic          r_rd_seen;
    logic          r_fwd;
    logic [PW-1:0] r_fwd_pos;

    // Window state.
    logic [PW-1:0] r_ws;
    logic [LW-1:0] r_best;

    // Output register.
    logic          r_out_valid;
    logic [LW-1:0] r_out_len;
    logic [LW-1:0] r_out_best;
    logic          r_out_ovf;

    logic          in_go;
    logic          s1_go;
    logic [SW-1:0] in_sym;
    logic [PW-1:0] n_pos;
    logic          n_ovf;
    logic [PW-1:0] prev;
    logic [PW-1:0] ws0;
    logic [PW-1:0] ws1;
    logic [PW-1:0] n_ws;
    logic [PW-1:0] diff;
    logic [LW-1:0] len;
    logic [LW-1:0] best0;
    logic [LW-1:0] n_best;

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_go      = i_in_valid && o_in_ready;
    assign in_sym     = ldrt_pkg::sym_of(i_char_in);

    always_comb begin
        if (r_pos == ldrt_pkg::POS_MAX) begin
            n_pos = r_pos;
            n_ovf = 1'b1;
        end else begin
            n_pos = r_pos + PW'(1);
            n_ovf = r_ovf;
        end
    end

    always_comb begin
        prev = r_fwd ? r_fwd_pos : (r_rd_seen ? r_rd : '0);
        ws0  = r_s1_first ? r_s1_pos : r_ws;
        if (prev != '0 && prev >= ws0) begin
            ws1 = (prev >= r_s1_pos) ? r_s1_pos : prev + PW'(1);
        end else begin
            ws1 = ws0;
        end
        n_ws = (ws1 > r_s1_pos) ? r_s1_pos : ws1;
        diff = r_s1_pos - n_ws;
        if (diff >= PW'(ldrt_pkg::LEN_CAP)) begin
            len = LW'(ldrt_pkg::LEN_CAP);
        end else begin
            len = diff[LW-1:0] + LW'(1);
        end
        best0  = r_s1_first ? '0 : r_best;
        n_best = (len > best0) ? len : best0;
    end

    // Table memory: read at acceptance, written when stage one retires.
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_mem[r_s1_sym] <= r_s1_pos;
        end
        if (in_go) begin
            r_rd <= r_mem[in_sym];
        end
    end

    // The write of the retiring item lands after the read of the new item,
    // so a match on the same symbol takes the retiring position directly.
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_rd_seen  <= r_seen[in_sym];
            r_fwd      <= s1_go && (r_s1_sym == in_sym);
            r_fwd_pos  <= r_s1_pos;
            r_s1_sym   <= in_sym;
            r_s1_pos   <= n_pos;
            r_s1_ovf   <= n_ovf;
            r_s1_first <= i_first_of_string;
        end
        if (s1_go) begin
            r_out_len  <= len;
            r_out_best <= n_best;
            r_out_ovf  <= r_s1_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_ws        <= PW'(1);
            r_best      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_seen[r_s1_sym] <= 1'b1;
                r_ws             <= n_ws;
                r_best           <= n_best;
            end
            if (in_go) begin
                r_pos <= n_pos;
                r_ovf <= n_ovf;
            end
            r_s1_valid  <= in_go || (r_s1_valid && !s1_go);
            r_out_valid <= s1_go || (r_out_valid && !i_out_ready);
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_window_length     = r_out_len;
    assign o_best_length       = r_out_best;
    assign o_position_overflow = r_out_ovf;

endmodule

@@ src/ldrt_checker.sv @@
module ldrt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [ldrt_pkg::CHAR_W-1:0] i_char_in,
    input logic                        i_first_of_string,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [ldrt_pkg::LEN_W-1:0]  o_window_length,
    input logic [ldrt_pkg::LEN_W-1:0]  o_best_length,
    input logic                        o_position_overflow
);

    localparam int LW = ldrt_pkg::LEN_W;

    // Nothing is left in flight after a reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_window_length) && $stable(o_best_length)
            && $stable(o_position_overflow))
        else $error("stalled result changed");

    // The window is never empty, and the best length covers it.
    a_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_window_length != '0
            && o_window_length <= o_best_length
            && o_best_length <= LW'(ldrt_pkg::LEN_CAP))
        else $error("window or best length out of range");

    // Overflow is sticky from one item to the next.
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_position_overflow |=> !o_out_valid || o_position_overflow)
        else $error("overflow flag cleared without reset");

endmodule

bind longest_distinct_run_tracker_unit ldrt_checker u_ldrt_checker (.*);
